>>> design/paged_address_translation_unit_macros.svh
// Assertion macros for the paged address translation unit.
// Used by the top level; expects a clk and rst_n in scope.
`ifndef PAGED_ADDRESS_TRANSLATION_UNIT_MACROS_SVH
`define PAGED_ADDRESS_TRANSLATION_UNIT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define PATU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expr must never be true out of reset
`define PATU_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/patu_pkg.sv
// Types, register addresses, masks and the page register map of the
// paged address translation unit. No dependencies.
`default_nettype none

package patu_pkg;

    localparam int PAGES   = 8;
    localparam int ENTRIES = 6 * PAGES;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam logic [17:0] R_MMR0 = 18'o777572;
    localparam logic [17:0] R_MMR1 = 18'o777574;
    localparam logic [17:0] R_MMR2 = 18'o777576;
    localparam logic [17:0] R_MMR3 = 18'o772516;

    localparam logic [15:0] MMR0_RESET = 16'h0280;
    localparam logic [15:0] MMR0_WMASK = 16'hF27F;
    localparam logic [15:0] MMR3_WMASK = 16'h0007;
    localparam logic [15:0] DESC_WMASK = 16'h7F0F;
    localparam logic [15:0] DESC_A     = 16'h0080;
    localparam logic [15:0] DESC_W     = 16'h0040;

    typedef enum logic [2:0] {
        CMD_REG_READ   = 3'd0,
        CMD_REG_WRITE  = 3'd1,
        CMD_TRANSLATE  = 3'd2,
        CMD_INST_DONE  = 3'd3,
        CMD_CLEAR_REC  = 3'd4,
        CMD_RECORD_REG = 3'd5,
        CMD_RECORD_PC  = 3'd6,
        CMD_NONE       = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_NONRES   = 3'd2,
        ST_RO_WRITE = 3'd3,
        ST_TRAP     = 3'd4,
        ST_BAD_REG  = 3'd5,
        ST_BAD_MODE = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        MODE_KERNEL  = 2'd0,
        MODE_SUPER   = 2'd1,
        MODE_USER    = 2'd2,
        MODE_INVALID = 2'd3
    } mode_t;

    // access control field of a page descriptor
    typedef enum logic [2:0] {
        ACF_NONRES0   = 3'd0,
        ACF_RO_TRAP   = 3'd1,
        ACF_RO        = 3'd2,
        ACF_NONRES3   = 3'd3,
        ACF_TRAP_ALL  = 3'd4,
        ACF_TRAP_WR   = 3'd5,
        ACF_RW        = 3'd6,
        ACF_NONRES7   = 3'd7
    } acf_t;

    typedef enum logic [1:0] {
        CFG_IO16_START = 2'd0,
        CFG_IO18_START = 2'd1,
        CFG_IO_TARGET  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [17:0] base;
        logic [1:0]  mode;
        logic        space;
        logic        is_base;
    } page_group_t;

    localparam int GROUPS = 12;

    localparam page_group_t PAGE_GROUPS [GROUPS] = '{
        '{18'o777600, MODE_USER,   1'b0, 1'b0}, '{18'o777620, MODE_USER,   1'b1, 1'b0},
        '{18'o772200, MODE_SUPER,  1'b0, 1'b0}, '{18'o772220, MODE_SUPER,  1'b1, 1'b0},
        '{18'o772300, MODE_KERNEL, 1'b0, 1'b0}, '{18'o772320, MODE_KERNEL, 1'b1, 1'b0},
        '{18'o777640, MODE_USER,   1'b0, 1'b1}, '{18'o777660, MODE_USER,   1'b1, 1'b1},
        '{18'o772240, MODE_SUPER,  1'b0, 1'b1}, '{18'o772260, MODE_SUPER,  1'b1, 1'b1},
        '{18'o772340, MODE_KERNEL, 1'b0, 1'b1}, '{18'o772360, MODE_KERNEL, 1'b1, 1'b1}
    };

    typedef struct packed {
        logic             hit;
        logic             is_base;
        logic [IDX_W-1:0] idx;
    } page_reg_t;

    // Each group covers 2*PAGES bytes on a 16-byte boundary; entry = {mode, space, page}.
    function automatic page_reg_t decode_page_reg(input logic [17:0] addr);
        page_reg_t r;
        r = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (addr[17:4] == PAGE_GROUPS[g].base[17:4]) begin
                r.hit     = 1'b1;
                r.is_base = PAGE_GROUPS[g].is_base;
                r.idx     = {PAGE_GROUPS[g].mode, PAGE_GROUPS[g].space, addr[3:1]};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/patu_ram.sv
// Generic RAM: one write port, two registered read ports with read enable.
// No dependencies.
`default_nettype none

module patu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> design/paged_address_translation_unit.sv
// Paged address translation unit: register file, page tables and translate path.
// Depends on patu_pkg, patu_ram and paged_address_translation_unit_macros.svh.
//
// One word can be accepted every cycle. Its result word is valid from the edge
// that moves it from stage 1 into the result register. The accept edge registers
// the word and reads the page base and descriptor RAMs (both spaces of the page
// at once). The edge that advances stage 1 runs the checks, the base add and the
// I/O page relocation, and loads the result register. While the result register
// waits, one more word is held in stage 1, and then the input stalls. One word per
// cycle is sustained while results are taken every cycle. Page tables read as zero
// after reset through per-entry valid bits; there is no clearing pass. Configuration
// is on a 32-bit APB port: io16_start at 0x0, io18_start at 0x4, io_target at 0x8.
`default_nettype none

module paged_address_translation_unit (
    input  logic               clk,
    input  logic               rst_n,
    // input words
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic [17:0]        bus_addr,
    input  logic [15:0]        wdata,
    input  logic               space,
    input  logic [1:0]         mode,
    input  logic               is_write,
    input  logic [2:0]         rec_reg,
    input  logic signed [4:0]  rec_diff,
    // result words
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        rdata,
    output logic [21:0]        phys_addr,
    output logic [2:0]         status,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import patu_pkg::*;

    `include "paged_address_translation_unit_macros.svh"

    // ---------------- configuration ----------------
    logic [15:0] io16_start_reg;
    logic [17:0] io18_start_reg;
    logic [21:0] io_target_reg;
    cfg_idx_t    cfg_idx;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = cfg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io16_start_reg <= 16'd57344;
            io18_start_reg <= 18'd253952;
            io_target_reg  <= 22'd4186112;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                CFG_IO16_START: io16_start_reg <= pwdata[15:0];
                CFG_IO18_START: io18_start_reg <= pwdata[17:0];
                CFG_IO_TARGET:  io_target_reg  <= pwdata[21:0];
                CFG_UNUSED:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            CFG_IO16_START: prdata = {16'd0, io16_start_reg};
            CFG_IO18_START: prdata = {14'd0, io18_start_reg};
            CFG_IO_TARGET:  prdata = {10'd0, io_target_reg};
            CFG_UNUSED:     prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg;
    logic s1_adv;
    logic in_fire;
    logic out_valid_reg;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // ---------------- stage 0: table read address ----------------
    cmd_t             in_cmd;
    mode_t            in_mode_rd;
    page_reg_t        in_dec;
    logic [IDX_W-1:0] rd_idx_a;
    logic [IDX_W-1:0] rd_idx_b;

    assign in_cmd     = cmd_t'(cmd);
    assign in_mode_rd = (mode_t'(mode) == MODE_INVALID) ? MODE_KERNEL : mode_t'(mode);
    assign in_dec     = decode_page_reg(bus_addr);

    // port a: register entry or instruction-space page; port b: data-space page
    always_comb
    begin
        if ((in_cmd == CMD_REG_READ || in_cmd == CMD_REG_WRITE) && in_dec.hit)
        begin
            rd_idx_a = in_dec.idx;
        end
        else
        begin
            rd_idx_a = {in_mode_rd, 1'b0, bus_addr[15:13]};
        end
        rd_idx_b = {in_mode_rd, 1'b1, bus_addr[15:13]};
    end

    // ---------------- page table RAMs ----------------
    logic             base_we;
    logic [IDX_W-1:0] base_widx;
    logic [15:0]      base_wdata;
    logic             descr_we;
    logic [IDX_W-1:0] descr_widx;
    logic [15:0]      descr_wdata;
    logic [15:0]      base_rd_a;
    logic [15:0]      base_rd_b;
    logic [15:0]      descr_rd_a;
    logic [15:0]      descr_rd_b;
    logic [ENTRIES-1:0] base_vld_reg;
    logic [ENTRIES-1:0] descr_vld_reg;

    patu_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_base_ram (
        .clk     (clk),
        .we      (base_we && s1_adv),
        .waddr   (base_widx),
        .wdata   (base_wdata),
        .re      (in_fire),
        .raddr_a (rd_idx_a),
        .raddr_b (rd_idx_b),
        .rdata_a (base_rd_a),
        .rdata_b (base_rd_b)
    );

    patu_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_descr_ram (
        .clk     (clk),
        .we      (descr_we && s1_adv),
        .waddr   (descr_widx),
        .wdata   (descr_wdata),
        .re      (in_fire),
        .raddr_a (rd_idx_a),
        .raddr_b (rd_idx_b),
        .rdata_a (descr_rd_a),
        .rdata_b (descr_rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_vld_reg  <= '0;
            descr_vld_reg <= '0;
        end
        else if (s1_adv)
        begin
            if (base_we)
            begin
                base_vld_reg[base_widx] <= 1'b1;
            end
            if (descr_we)
            begin
                descr_vld_reg[descr_widx] <= 1'b1;
            end
        end
    end

    // ---------------- stage 1 registers ----------------
    cmd_t             cmd_reg;
    logic [17:0]      addr_reg;
    logic [15:0]      wdata_reg;
    logic             space_reg;
    mode_t            mode_reg;
    logic             is_write_reg;
    logic [2:0]       rec_reg_reg;
    logic [4:0]       rec_diff_reg;
    logic [IDX_W-1:0] idx_a_reg;
    logic [IDX_W-1:0] idx_b_reg;
    // a table write on the accept edge is missed by the RAM read; forward it
    logic             fwd_base_a_reg;
    logic             fwd_base_b_reg;
    logic             fwd_descr_a_reg;
    logic             fwd_descr_b_reg;
    logic [15:0]      fwd_base_data_reg;
    logic [15:0]      fwd_descr_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg            <= in_cmd;
            addr_reg           <= bus_addr;
            wdata_reg          <= wdata;
            space_reg          <= space;
            mode_reg           <= mode_t'(mode);
            is_write_reg       <= is_write;
            rec_reg_reg        <= rec_reg;
            rec_diff_reg       <= rec_diff;
            idx_a_reg          <= rd_idx_a;
            idx_b_reg          <= rd_idx_b;
            fwd_base_a_reg     <= s1_adv && base_we && (base_widx == rd_idx_a);
            fwd_base_b_reg     <= s1_adv && base_we && (base_widx == rd_idx_b);
            fwd_descr_a_reg    <= s1_adv && descr_we && (descr_widx == rd_idx_a);
            fwd_descr_b_reg    <= s1_adv && descr_we && (descr_widx == rd_idx_b);
            fwd_base_data_reg  <= base_wdata;
            fwd_descr_data_reg <= descr_wdata;
        end
    end

    // ---------------- stage 1: table entries as seen by this word ----------------
    logic [15:0] base_a;
    logic [15:0] base_b;
    logic [15:0] descr_a;
    logic [15:0] descr_b;

    assign base_a  = fwd_base_a_reg  ? fwd_base_data_reg  :
                     (base_vld_reg[idx_a_reg]  ? base_rd_a  : 16'd0);
    assign base_b  = fwd_base_b_reg  ? fwd_base_data_reg  :
                     (base_vld_reg[idx_b_reg]  ? base_rd_b  : 16'd0);
    assign descr_a = fwd_descr_a_reg ? fwd_descr_data_reg :
                     (descr_vld_reg[idx_a_reg] ? descr_rd_a : 16'd0);
    assign descr_b = fwd_descr_b_reg ? fwd_descr_data_reg :
                     (descr_vld_reg[idx_b_reg] ? descr_rd_b : 16'd0);

    // ---------------- status registers ----------------
    logic [15:0] mmr_status_reg;
    logic [15:0] mmr_record_reg;
    logic [15:0] mmr_pc_reg;
    logic [15:0] mmr_config_reg;
    logic [15:0] mmr_status_next;
    logic [15:0] mmr_record_next;
    logic [15:0] mmr_pc_next;
    logic [15:0] mmr_config_next;

    // ---------------- translate path ----------------
    logic        reloc_on;
    logic        d_space_en;
    logic        space_eff;
    logic [15:0] va;
    logic [21:0] pa16;
    logic [15:0] tr_descr;
    logic [15:0] tr_base;
    logic [6:0]  blk;
    logic [6:0]  plf;
    logic        len_fail;
    acf_t        acf;
    logic        set_a;
    logic        tr_abort;
    status_t     tr_status;
    logic [11:0] frame;
    logic [17:0] pa18;
    logic [21:0] pa_mapped;

    assign reloc_on = mmr_status_reg[0];
    assign va       = addr_reg[15:0];
    assign pa16     = (va >= io16_start_reg) ?
                      ({6'd0, va} - {6'd0, io16_start_reg} + io_target_reg) : {6'd0, va};

    always_comb
    begin
        unique case (mode_reg)
            MODE_KERNEL:  d_space_en = mmr_config_reg[2];
            MODE_SUPER:   d_space_en = mmr_config_reg[1];
            MODE_USER:    d_space_en = mmr_config_reg[0];
            MODE_INVALID: d_space_en = 1'b0;
        endcase
    end

    assign space_eff = space_reg && d_space_en;
    assign tr_descr  = space_eff ? descr_b : descr_a;
    assign tr_base   = space_eff ? base_b  : base_a;
    assign blk       = va[12:6];
    assign plf       = tr_descr[14:8];
    assign acf       = acf_t'(tr_descr[2:0]);
    // expansion direction bit flips the sense of the length check
    assign len_fail  = tr_descr[3] ? (blk < plf) : (blk > plf);

    always_comb
    begin
        set_a     = 1'b0;
        tr_abort  = 1'b0;
        tr_status = ST_OK;
        if (len_fail)
        begin
            tr_abort  = 1'b1;
            tr_status = ST_LENGTH;
        end
        else
        begin
            unique case (acf)
                ACF_RO_TRAP:
                begin
                    if (is_write_reg)
                    begin
                        tr_abort  = 1'b1;
                        tr_status = ST_RO_WRITE;
                    end
                    else
                    begin
                        set_a     = 1'b1;
                        tr_status = ST_TRAP;
                    end
                end
                ACF_RO:
                begin
                    if (is_write_reg)
                    begin
                        set_a     = 1'b1;
                        tr_abort  = 1'b1;
                        tr_status = ST_RO_WRITE;
                    end
                end
                ACF_TRAP_ALL:
                begin
                    set_a     = 1'b1;
                    tr_status = ST_TRAP;
                end
                ACF_TRAP_WR:
                begin
                    if (is_write_reg)
                    begin
                        set_a     = 1'b1;
                        tr_status = ST_TRAP;
                    end
                end
                ACF_RW: ;
                ACF_NONRES0, ACF_NONRES3, ACF_NONRES7:
                begin
                    tr_abort  = 1'b1;
                    tr_status = ST_NONRES;
                end
            endcase
        end
    end

    // 18-bit mapped address, then move the I/O page
    assign frame     = tr_base[11:0] + {5'd0, blk};
    assign pa18      = {frame, va[5:0]};
    assign pa_mapped = (pa18 >= io18_start_reg) ?
                       ({4'd0, pa18} - {4'd0, io18_start_reg} + io_target_reg) :
                       {4'd0, pa18};

    // ---------------- stage 1: command execution ----------------
    logic        locked;
    page_reg_t   s1_dec;
    logic        reg_wr;
    logic [15:0] res_rdata;
    logic [21:0] res_phys;
    status_t     res_status;

    assign locked = mmr_status_reg[15:13] != 3'd0;
    assign s1_dec = decode_page_reg(addr_reg);
    assign reg_wr = (cmd_reg == CMD_REG_WRITE);

    always_comb
    begin
        mmr_status_next = mmr_status_reg;
        mmr_record_next = mmr_record_reg;
        mmr_pc_next     = mmr_pc_reg;
        mmr_config_next = mmr_config_reg;
        base_we         = 1'b0;
        base_widx       = idx_a_reg;
        base_wdata      = wdata_reg;
        descr_we        = 1'b0;
        descr_widx      = idx_a_reg;
        descr_wdata     = wdata_reg & DESC_WMASK;
        res_rdata       = 16'd0;
        res_phys        = 22'd0;
        res_status      = ST_OK;

        unique case (cmd_reg)
            CMD_REG_READ, CMD_REG_WRITE:
            begin
                priority if (addr_reg[0])
                begin
                    res_status = ST_BAD_REG;
                end
                else if (addr_reg == R_MMR0)
                begin
                    if (reg_wr) mmr_status_next = wdata_reg & MMR0_WMASK;
                    else        res_rdata = mmr_status_reg;
                end
                else if (addr_reg == R_MMR1)
                begin
                    if (reg_wr) mmr_record_next = wdata_reg;
                    else        res_rdata = mmr_record_reg;
                end
                else if (addr_reg == R_MMR2)
                begin
                    if (!reg_wr) res_rdata = mmr_pc_reg;
                end
                else if (addr_reg == R_MMR3)
                begin
                    if (reg_wr) mmr_config_next = wdata_reg & MMR3_WMASK;
                    else        res_rdata = mmr_config_reg;
                end
                else if (s1_dec.hit)
                begin
                    if (s1_dec.is_base)
                    begin
                        if (reg_wr)
                        begin
                            // new base clears the accessed and written flags
                            base_we     = 1'b1;
                            descr_we    = 1'b1;
                            descr_wdata = descr_a & ~(DESC_A | DESC_W);
                        end
                        else
                        begin
                            res_rdata = base_a;
                        end
                    end
                    else
                    begin
                        if (reg_wr) descr_we = 1'b1;
                        else        res_rdata = descr_a;
                    end
                end
                else
                begin
                    res_status = ST_BAD_REG;
                end
            end
            CMD_TRANSLATE:
            begin
                priority if (!reloc_on)
                begin
                    res_phys = pa16;
                end
                else if (mode_reg == MODE_INVALID)
                begin
                    res_status = ST_BAD_MODE;
                end
                else
                begin
                    res_status  = tr_status;
                    res_phys    = tr_abort ? 22'd0 : pa_mapped;
                    descr_we    = set_a;
                    descr_widx  = space_eff ? idx_b_reg : idx_a_reg;
                    descr_wdata = tr_descr | DESC_A;
                end
            end
            CMD_INST_DONE:
            begin
                mmr_status_next = {mmr_status_reg[15:8], wdata_reg[0], mmr_status_reg[6:0]};
            end
            CMD_CLEAR_REC:
            begin
                if (!locked) mmr_record_next = 16'd0;
            end
            CMD_RECORD_REG:
            begin
                if (!locked) mmr_record_next = {mmr_record_reg[7:0], rec_diff_reg, rec_reg_reg};
            end
            CMD_RECORD_PC:
            begin
                if (!locked) mmr_pc_next = wdata_reg;
            end
            CMD_NONE: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mmr_status_reg <= MMR0_RESET;
            mmr_record_reg <= 16'd0;
            mmr_pc_reg     <= 16'd0;
            mmr_config_reg <= 16'd0;
        end
        else if (s1_adv)
        begin
            mmr_status_reg <= mmr_status_next;
            mmr_record_reg <= mmr_record_next;
            mmr_pc_reg     <= mmr_pc_next;
            mmr_config_reg <= mmr_config_next;
        end
    end

    // ---------------- result register ----------------
    logic [15:0] rdata_reg;
    logic [21:0] phys_reg;
    status_t     status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            rdata_reg  <= res_rdata;
            phys_reg   <= res_phys;
            status_reg <= res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign rdata     = rdata_reg;
    assign phys_addr = phys_reg;
    assign status    = status_reg;

    // ---------------- assertions ----------------
    logic out_aborted;
    logic s1_stalled;

    assign out_aborted = out_valid_reg && status_reg != ST_OK && status_reg != ST_TRAP;
    assign s1_stalled  = s1_valid_reg && out_valid_reg && !out_ready;

    `PATU_NEVER(a_mmr0_mask, (mmr_status_reg & 16'h0D00) != 16'd0, "MMR0 reserved bits set")
    `PATU_NEVER(a_mmr3_mask, mmr_config_reg[15:3] != 13'd0, "MMR3 reserved bits set")
    `PATU_ASSERT(a_abort_phys, out_aborted |-> phys_reg == 22'd0, "aborted word has an address")
    `PATU_ASSERT(a_stall_holds, s1_stalled |=> s1_valid_reg && $stable(cmd_reg), "stalled word lost")
    `PATU_ASSERT(a_tbl_we, (base_we || descr_we) && !s1_valid_reg |-> !s1_adv, "stray table write")

endmodule

`default_nettype wire

>>> dv/tb_paged_address_translation_unit.sv
// Self-checking testbench for paged_address_translation_unit: directed and random words,
// checked against a predictor of the register file, page tables and translate path.
// Depends on patu_pkg and the RTL of the block.

module tb_paged_address_translation_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import patu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NPAGE       = 8;

    localparam logic [17:0] A_MMR0 = 18'o777572;
    localparam logic [17:0] A_MMR1 = 18'o777574;
    localparam logic [17:0] A_MMR2 = 18'o777576;
    localparam logic [17:0] A_MMR3 = 18'o772516;

    localparam logic [15:0] MMR0_INIT    = 16'h0280;
    localparam logic [15:0] MMR0_WR_MASK = 16'hF27F;
    localparam logic [15:0] MMR3_WR_MASK = 16'h0007;
    localparam logic [15:0] PD_WR_MASK   = 16'h7F0F;
    localparam logic [15:0] PD_A         = 16'h0080;
    localparam logic [15:0] PD_W         = 16'h0040;

    // descriptor groups first (user I/D, super I/D, kernel I/D), then base groups
    localparam logic [17:0] PG_ADDR [12] = '{
        18'o777600, 18'o777620, 18'o772200, 18'o772220, 18'o772300, 18'o772320,
        18'o777640, 18'o777660, 18'o772240, 18'o772260, 18'o772340, 18'o772360
    };

    typedef struct {
        cmd_t               cmd;
        logic [17:0]        addr;
        logic [15:0]        wdata;
        logic               space;
        logic [1:0]         mode;
        logic               is_write;
        logic [2:0]         rec_reg;
        logic signed [4:0]  rec_diff;
    } mmu_word_t;

    typedef struct {
        logic [15:0] rdata;
        logic [21:0] phys;
        status_t     status;
    } mmu_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         cmd;
    logic [17:0]        bus_addr;
    logic [15:0]        wdata;
    logic               space;
    logic [1:0]         mode;
    logic               is_write;
    logic [2:0]         rec_reg;
    logic signed [4:0]  rec_diff;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        rdata;
    logic [21:0]        phys_addr;
    logic [2:0]         status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    paged_address_translation_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .bus_addr  (bus_addr),
        .wdata     (wdata),
        .space     (space),
        .mode      (mode),
        .is_write  (is_write),
        .rec_reg   (rec_reg),
        .rec_diff  (rec_diff),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rdata     (rdata),
        .phys_addr (phys_addr),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // predicted block state
    logic [15:0] mmr0, mmr1, mmr2, mmr3;
    logic [15:0] pbase [6*NPAGE];
    logic [15:0] pdesc [6*NPAGE];
    logic [15:0] cfg_io16;
    logic [17:0] cfg_io18;
    logic [21:0] cfg_target;

    mmu_word_t   pending_words [$];
    mmu_result_t expected_results [$];
    mmu_word_t   cur_word;
    mmu_result_t want;

    int  errors         = 0;
    int  cycles         = 0;
    int  queued_words   = 0;
    int  accepted_words = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    int  send_gap_pct   = 0;
    int  recv_gap_pct   = 0;
    bit  offering       = 0;
    bit  in_taken       = 0;
    bit  hold_off       = 0;

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic bit find_page_reg(input logic [17:0] a, output int idx,
                                         output bit is_par);
        int g;
        find_page_reg = 0;
        idx = 0;
        is_par = 0;
        for (g = 0; g < 12; g++) begin
            if (a >= PG_ADDR[g] && a < PG_ADDR[g] + 18'd16) begin
                idx = (2 - (g % 6) / 2) * 2 * NPAGE + (g % 2) * NPAGE
                      + int'((a - PG_ADDR[g]) >> 1);
                is_par = (g >= 6);
                find_page_reg = 1;
            end
        end
    endfunction

    function automatic logic [17:0] page_reg_addr(int m, int sp, int pg, bit is_par);
        return PG_ADDR[(is_par ? 6 : 0) + (2 - m) * 2 + sp] + 18'(2 * pg);
    endfunction

    // Applies one word to the predicted state and returns its result word.
    function automatic mmu_result_t mmu_apply(input mmu_word_t w);
        mmu_result_t r;
        logic        locked;
        logic        wr;
        int          idx;
        bit          is_par;
        logic [15:0] va;
        logic [15:0] d;
        logic [6:0]  blk;
        logic [6:0]  plf;
        logic        sp;
        logic [31:0] pa;
        bit          abort;
        r.rdata = '0;
        r.phys = '0;
        r.status = ST_OK;
        locked = |mmr0[15:13];
        if (w.cmd == CMD_REG_READ || w.cmd == CMD_REG_WRITE) begin
            wr = (w.cmd == CMD_REG_WRITE);
            if (w.addr[0])
                r.status = ST_BAD_REG;
            else if (w.addr == A_MMR0) begin
                if (wr) mmr0 = w.wdata & MMR0_WR_MASK;
                else r.rdata = mmr0;
            end else if (w.addr == A_MMR1) begin
                if (wr) mmr1 = w.wdata;
                else r.rdata = mmr1;
            end else if (w.addr == A_MMR2) begin
                if (!wr) r.rdata = mmr2;
            end else if (w.addr == A_MMR3) begin
                if (wr) mmr3 = w.wdata & MMR3_WR_MASK;
                else r.rdata = mmr3;
            end else if (find_page_reg(w.addr, idx, is_par)) begin
                if (is_par && wr) begin
                    pbase[idx] = w.wdata;
                    pdesc[idx] = pdesc[idx] & ~(PD_A | PD_W);
                end else if (is_par)
                    r.rdata = pbase[idx];
                else if (wr)
                    pdesc[idx] = w.wdata & PD_WR_MASK;
                else
                    r.rdata = pdesc[idx];
            end else
                r.status = ST_BAD_REG;
            return r;
        end
        case (w.cmd)
            CMD_TRANSLATE: begin
                va = w.addr[15:0];
                if (!mmr0[0]) begin
                    pa = 32'(va);
                    if (32'(va) >= 32'(cfg_io16))
                        pa = (32'(va) - 32'(cfg_io16) + 32'(cfg_target)) & 32'h3FFFFF;
                    r.phys = pa[21:0];
                end else if (w.mode == MODE_INVALID)
                    r.status = ST_BAD_MODE;
                else begin
                    // D space falls back to I space unless enabled for the mode
                    sp = mmr3[2 - int'(w.mode)] ? w.space : 1'b0;
                    idx = int'(w.mode) * 2 * NPAGE + int'(sp) * NPAGE + int'(va[15:13]);
                    d = pdesc[idx];
                    blk = va[12:6];
                    plf = d[14:8];
                    abort = 0;
                    if (d[3] ? (blk < plf) : (blk > plf)) begin
                        r.status = ST_LENGTH;
                        abort = 1;
                    end else begin
                        case (acf_t'(d[2:0]))
                            ACF_RO_TRAP: begin
                                if (w.is_write) begin
                                    r.status = ST_RO_WRITE;
                                    abort = 1;
                                end else begin
                                    d = d | PD_A;
                                    r.status = ST_TRAP;
                                end
                            end
                            ACF_RO: begin
                                if (w.is_write) begin
                                    d = d | PD_A;
                                    r.status = ST_RO_WRITE;
                                    abort = 1;
                                end
                            end
                            ACF_TRAP_ALL: begin
                                d = d | PD_A;
                                r.status = ST_TRAP;
                            end
                            ACF_TRAP_WR: begin
                                if (w.is_write) begin
                                    d = d | PD_A;
                                    r.status = ST_TRAP;
                                end
                            end
                            ACF_RW: ;
                            default: begin
                                r.status = ST_NONRES;
                                abort = 1;
                            end
                        endcase
                    end
                    pdesc[idx] = d;
                    if (!abort) begin
                        pa = (((32'(pbase[idx]) + 32'(blk)) << 6) | 32'(va[5:0])) & 32'h3FFFF;
                        if (pa >= 32'(cfg_io18))
                            pa = (pa - 32'(cfg_io18) + 32'(cfg_target)) & 32'h3FFFFF;
                        r.phys = pa[21:0];
                    end
                end
            end
            CMD_INST_DONE:  mmr0[7] = w.wdata[0];
            CMD_CLEAR_REC:  if (!locked) mmr1 = '0;
            CMD_RECORD_REG: if (!locked) mmr1 = {mmr1[7:0], w.rec_diff, w.rec_reg};
            CMD_RECORD_PC:  if (!locked) mmr2 = w.wdata;
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap(int pct);
        int r;
        r = $urandom_range(0, 99);
        if (r >= pct) return 0;
        if (r < 2) return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, what, want_v, got_v);
        end
    endtask

    // sender: after the last word is taken, a new word goes out at a falling edge once the random send gap has run down
    always @(negedge clk) begin
        if (in_taken) begin
            in_taken = 0;
            offering = 0;
            send_gap = pick_gap(send_gap_pct);
        end
        if (rst_n && !offering) begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_words.size() != 0) begin
                cur_word = pending_words.pop_front();
                offering = 1;
                cmd      <= cur_word.cmd;
                bus_addr <= cur_word.addr;
                wdata    <= cur_word.wdata;
                space    <= cur_word.space;
                mode     <= cur_word.mode;
                is_write <= cur_word.is_write;
                rec_reg  <= cur_word.rec_reg;
                rec_diff <= cur_word.rec_diff;
            end
        end
        in_valid <= offering;
    end

    // receiver stalls
    always @(negedge clk) begin
        if (hold_off || stall_left > 0) begin
            if (stall_left > 0) stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            stall_left = pick_gap(recv_gap_pct);
        end
    end

    // monitor: input words are predicted before result words are checked
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            expected_results.push_back(mmu_apply(cur_word));
            accepted_words++;
            in_taken = 1;
        end
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result word rdata 0x%0h phys 0x%0h status %0d",
                         $time, rdata, phys_addr, status);
            end else begin
                want = expected_results.pop_front();
                check_field("rdata", 32'(want.rdata), 32'(rdata));
                check_field("phys_addr", 32'(want.phys), 32'(phys_addr));
                check_field("status", 32'(want.status), 32'(status));
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // long receiver hold-off in mid-run, so the block backs up onto its input
    initial begin
        wait (accepted_words >= 300);
        @(posedge clk);
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
    end

    task automatic push_word(cmd_t c, logic [17:0] a, logic [15:0] wd, logic [1:0] m,
                             logic sp, logic wr, logic [2:0] rr, logic signed [4:0] rd);
        mmu_word_t w;
        w.cmd = c;
        w.addr = a;
        w.wdata = wd;
        w.mode = m;
        w.space = sp;
        w.is_write = wr;
        w.rec_reg = rr;
        w.rec_diff = rd;
        pending_words.push_back(w);
        queued_words++;
    endtask

    task automatic queue_random_words(int n);
        mmu_word_t w;
        int        pick;
        repeat (n) begin
            w.cmd = cmd_t'($urandom_range(0, 7));
            w.addr = 18'($urandom);
            w.wdata = 16'($urandom);
            w.space = 1'($urandom);
            w.mode = 2'($urandom);
            w.is_write = 1'($urandom);
            w.rec_reg = 3'($urandom);
            w.rec_diff = 5'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                w.cmd = CMD_TRANSLATE;
                if (w.mode == MODE_INVALID && $urandom_range(0, 4) != 0)
                    w.mode = 2'($urandom_range(0, 2));
            end else if (pick < 60) begin
                w.cmd = CMD_REG_WRITE;
                w.addr = page_reg_addr($urandom_range(0, 2), w.space, $urandom_range(0, 7), 0);
            end else if (pick < 67) begin
                w.cmd = CMD_REG_WRITE;
                w.addr = page_reg_addr($urandom_range(0, 2), w.space, $urandom_range(0, 7), 1);
            end else if (pick < 75) begin
                w.cmd = CMD_REG_READ;
                w.addr = page_reg_addr($urandom_range(0, 2), w.space, $urandom_range(0, 7),
                                       $urandom_range(0, 1));
            end else if (pick < 83) begin
                w.cmd = $urandom_range(0, 1) ? CMD_REG_READ : CMD_REG_WRITE;
                case ($urandom_range(0, 3))
                    0: w.addr = A_MMR0;
                    1: w.addr = A_MMR1;
                    2: w.addr = A_MMR2;
                    default: w.addr = A_MMR3;
                endcase
                // keep relocation on and the error lock clear most of the time
                if ($urandom_range(0, 3) != 0) w.wdata[15:13] = 3'b000;
                if ($urandom_range(0, 4) != 0) w.wdata[0] = 1'b1;
            end else if (pick < 93)
                w.cmd = cmd_t'($urandom_range(3, 6));
            pending_words.push_back(w);
            queued_words++;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (accepted_words != queued_words || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(cfg_idx_t r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            CFG_IO16_START: cfg_io16 = v[15:0];
            CFG_IO18_START: cfg_io18 = v[17:0];
            CFG_IO_TARGET:  cfg_target = v[21:0];
            default: ;
        endcase
    endtask

    initial begin : main_seq
        int          ph;
        logic [31:0] v16;
        logic [31:0] v18;
        logic [31:0] vtgt;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = '0;
        bus_addr = '0;
        wdata = '0;
        space = 1'b0;
        mode = '0;
        is_write = 1'b0;
        rec_reg = '0;
        rec_diff = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mmr0 = MMR0_INIT;
        mmr1 = '0;
        mmr2 = '0;
        mmr3 = '0;
        for (int i = 0; i < 6 * NPAGE; i++) begin
            pbase[i] = '0;
            pdesc[i] = '0;
        end
        cfg_io16 = 16'd57344;
        cfg_io18 = 18'd253952;
        cfg_target = 22'd4186112;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        send_gap_pct = 10;
        recv_gap_pct = 10;
        // relocation off: top of the space lands in the I/O page, mode is ignored
        push_word(CMD_TRANSLATE, 18'h0FFFF, 16'h0, MODE_KERNEL, 1'b0, 1'b1, 3'd0, 5'sh00);
        push_word(CMD_TRANSLATE, 18'h30000, 16'h0, MODE_INVALID, 1'b1, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_READ, A_MMR0, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_READ, A_MMR2 + 18'd1, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_WRITE, 18'o772400, 16'hFFFF, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_WRITE, A_MMR2, 16'hFFFF, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_RECORD_REG, 18'h0, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd7, 5'sh10);
        push_word(CMD_RECORD_REG, 18'h0, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh0F);
        push_word(CMD_RECORD_PC, 18'h0, 16'hFFFF, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_READ, A_MMR1, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_READ, A_MMR2, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_CLEAR_REC, 18'h0, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_INST_DONE, 18'h0, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_READ, A_MMR0, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_WRITE, A_MMR3, 16'hFFFF, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_WRITE, page_reg_addr(0, 1, 7, 1), 16'hFFFF, MODE_KERNEL, 1'b0,
                  1'b0, 3'd0, 5'sh00);
        // downward page, longest length, non-resident
        push_word(CMD_REG_WRITE, page_reg_addr(0, 1, 7, 0), 16'hFFFF, MODE_KERNEL, 1'b0,
                  1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_READ, page_reg_addr(0, 1, 7, 0), 16'h0, MODE_KERNEL, 1'b0, 1'b0,
                  3'd0, 5'sh00);
        push_word(CMD_REG_WRITE, page_reg_addr(0, 1, 7, 0), 16'h7F06, MODE_KERNEL, 1'b0,
                  1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_WRITE, A_MMR0, 16'h0001, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        // largest base plus largest block wraps at 18 bits
        push_word(CMD_TRANSLATE, 18'h0FFFF, 16'h0, MODE_KERNEL, 1'b1, 1'b1, 3'd0, 5'sh00);
        push_word(CMD_TRANSLATE, 18'h00000, 16'h0, MODE_INVALID, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_NONE, 18'h3FFFF, 16'hFFFF, MODE_INVALID, 1'b1, 1'b1, 3'd7, 5'sh0F);
        // error bits set: recording is frozen
        push_word(CMD_REG_WRITE, A_MMR0, 16'hFFFF, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_RECORD_PC, 18'h0, 16'h1234, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_READ, A_MMR2, 16'h0, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_REG_WRITE, A_MMR0, 16'h0001, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        push_word(CMD_INST_DONE, 18'h0, 16'h0001, MODE_KERNEL, 1'b0, 1'b0, 3'd0, 5'sh00);
        wait_idle();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    v16 = 32'h0000FFFF; v18 = 32'h0003FFFF; vtgt = 32'h003FFFFF;
                    send_gap_pct = 15; recv_gap_pct = 15;
                end
                1: begin
                    v16 = 0; v18 = 0; vtgt = 0;
                    send_gap_pct = 0; recv_gap_pct = 0;
                end
                3: begin
                    v16 = 32'h8000; v18 = 32'h20000; vtgt = 32'($urandom_range(0, 32'h3FFFFF));
                    send_gap_pct = 30; recv_gap_pct = 10;
                end
                5: begin
                    v16 = 57344; v18 = 253952; vtgt = 4186112;
                    send_gap_pct = 15; recv_gap_pct = 15;
                end
                default: begin
                    v16 = 32'($urandom_range(0, 32'hFFFF));
                    v18 = 32'($urandom_range(0, 32'h3FFFF));
                    vtgt = 32'($urandom_range(0, 32'h3FFFFF));
                    send_gap_pct = 10 + 10 * ph; recv_gap_pct = 50 - 10 * ph;
                end
            endcase
            apb_write(CFG_IO16_START, v16);
            apb_write(CFG_IO18_START, v18);
            apb_write(CFG_IO_TARGET, vtgt);
            queue_random_words(113);
            wait_idle();
        end

        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/patu_pkg.sv
design/patu_ram.sv
design/paged_address_translation_unit.sv
dv/tb_paged_address_translation_unit.sv
